>>> rtl/mrb_pkg.sv
`default_nettype none
package mrb_pkg;

   localparam int unsigned SLOTS        = 1024;
   localparam int unsigned CHANNELS     = 8;
   localparam int unsigned ELEMENT_BITS = 16;

   localparam int unsigned POS_W   = $clog2(SLOTS);
   localparam int unsigned CHAN_W  = 3;
   localparam int unsigned ADDR_W  = CHAN_W + POS_W;
   localparam int unsigned DEPTH   = CHANNELS * SLOTS;
   localparam int unsigned ACT_W   = 3;
   localparam int unsigned OFF_W   = 10;
   localparam int unsigned CNT_W   = 11;
   localparam int unsigned GRANT_W = 12;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned WSP_W   = 10;
   localparam int unsigned RSP_W   = 11;
   localparam int unsigned TALLY_W = 16;
   localparam int unsigned CIDX_W  = 3;
   localparam int unsigned CDAT_W  = 11;
   localparam int unsigned RSV_W   = 10;
   localparam int unsigned NCH_W   = 4;

   localparam logic [ACT_W-1:0] ACT_WRITE_ELEM  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_COMMIT_WR   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_READ_ELEM   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_COMMIT_RD   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CHUNK_READ  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NO_DATA  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_BAD_CHAN = 2'd3;

   localparam logic [CIDX_W-1:0] CSR_RING_SLOTS    = 3'd0;
   localparam logic [CIDX_W-1:0] CSR_CHUNK_RESERVE = 3'd1;
   localparam logic [CIDX_W-1:0] CSR_CHANNELS      = 3'd2;
   localparam logic [CIDX_W-1:0] CSR_PARTIAL_WR    = 3'd3;
   localparam logic [CIDX_W-1:0] CSR_PARTIAL_RD    = 3'd4;

   typedef struct packed {
      logic capture;
      logic execute;
      logic cfg_we;
   } ctrl_cmd_type;

endpackage
`default_nettype wire

>>> rtl/multichannel_ring_buffer_core.sv
// channel   handshake              payload
// request   start / busy           req_action req_channel req_offset req_count req_data
// response  rsp_valid (strobe)     rsp_granted rsp_read_data rsp_status rsp_write_space
//                                  rsp_read_space rsp_overflow_count rsp_underflow_count
// config    csr_valid / csr_ready  csr_index csr_wdata
//
// An item is taken when start is high and busy is low; busy is high for the one
// execute cycle, and the response strobes on the cycle after it. The responses and
// the read port of the slot RAM are registered. A new item may be taken during the
// response cycle. csr_ready is low while busy. Synchronous reset clears positions
// and tallies and sets configuration to its defaults; slot RAM is not cleared.
`default_nettype none
module multichannel_ring_buffer_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [mrb_pkg::ACT_W-1:0]          req_action,
   input  wire logic [mrb_pkg::CHAN_W-1:0]         req_channel,
   input  wire logic [mrb_pkg::OFF_W-1:0]          req_offset,
   input  wire logic [mrb_pkg::CNT_W-1:0]          req_count,
   input  wire logic [mrb_pkg::ELEMENT_BITS-1:0]   req_data,
   output logic                                    rsp_valid,
   output logic signed [mrb_pkg::GRANT_W-1:0]      rsp_granted,
   output logic [mrb_pkg::ELEMENT_BITS-1:0]        rsp_read_data,
   output logic [mrb_pkg::STAT_W-1:0]              rsp_status,
   output logic [mrb_pkg::WSP_W-1:0]               rsp_write_space,
   output logic signed [mrb_pkg::RSP_W-1:0]        rsp_read_space,
   output logic [mrb_pkg::TALLY_W-1:0]             rsp_overflow_count,
   output logic [mrb_pkg::TALLY_W-1:0]             rsp_underflow_count,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mrb_pkg::CIDX_W-1:0]         csr_index,
   input  wire logic [mrb_pkg::CDAT_W-1:0]         csr_wdata
);

   mrb_pkg::ctrl_cmd_type cmd;

   mrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   mrb_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_action          (req_action),
      .req_channel         (req_channel),
      .req_offset          (req_offset),
      .req_count           (req_count),
      .req_data            (req_data),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_granted         (rsp_granted),
      .rsp_read_data       (rsp_read_data),
      .rsp_status          (rsp_status),
      .rsp_write_space     (rsp_write_space),
      .rsp_read_space      (rsp_read_space),
      .rsp_overflow_count  (rsp_overflow_count),
      .rsp_underflow_count (rsp_underflow_count)
   );

endmodule
`default_nettype wire

>>> rtl/mrb_ram.sv
`default_nettype none
module mrb_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/mrb_ctrl.sv
`default_nettype none
module mrb_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  csr_valid,
   output logic                       busy,
   output logic                       rsp_valid,
   output logic                       csr_ready,
   output mrb_pkg::ctrl_cmd_type      cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign busy      = (state_ff == ST_EXEC);
   assign rsp_valid = (state_ff == ST_RESP);
   assign csr_ready = ~busy;

   assign cmd.capture = start & ~busy;
   assign cmd.execute = busy;
   assign cmd.cfg_we  = csr_valid & ~busy;

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = start ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: state_in = start ? ST_EXEC : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/mrb_dp.sv
`default_nettype none
module mrb_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire mrb_pkg::ctrl_cmd_type              cmd,
   input  wire logic [mrb_pkg::ACT_W-1:0]          req_action,
   input  wire logic [mrb_pkg::CHAN_W-1:0]         req_channel,
   input  wire logic [mrb_pkg::OFF_W-1:0]          req_offset,
   input  wire logic [mrb_pkg::CNT_W-1:0]          req_count,
   input  wire logic [mrb_pkg::ELEMENT_BITS-1:0]   req_data,
   input  wire logic [mrb_pkg::CIDX_W-1:0]         csr_index,
   input  wire logic [mrb_pkg::CDAT_W-1:0]         csr_wdata,
   output logic signed [mrb_pkg::GRANT_W-1:0]      rsp_granted,
   output logic [mrb_pkg::ELEMENT_BITS-1:0]        rsp_read_data,
   output logic [mrb_pkg::STAT_W-1:0]              rsp_status,
   output logic [mrb_pkg::WSP_W-1:0]               rsp_write_space,
   output logic signed [mrb_pkg::RSP_W-1:0]        rsp_read_space,
   output logic [mrb_pkg::TALLY_W-1:0]             rsp_overflow_count,
   output logic [mrb_pkg::TALLY_W-1:0]             rsp_underflow_count
);

   // configuration
   logic [mrb_pkg::CNT_W-1:0] ring_slots_ff, ring_slots_in;
   logic [mrb_pkg::RSV_W-1:0] reserve_ff, reserve_in;
   logic [mrb_pkg::NCH_W-1:0] nch_ff, nch_in;
   logic                      pwr_ff, pwr_in;
   logic                      prd_ff, prd_in;

   // state
   logic [mrb_pkg::POS_W-1:0]   wp_ff, wp_in;
   logic [mrb_pkg::POS_W-1:0]   rp_ff, rp_in;
   logic [mrb_pkg::TALLY_W-1:0] ovf_ff, ovf_in;
   logic [mrb_pkg::TALLY_W-1:0] udf_ff, udf_in;

   // captured item
   logic [mrb_pkg::ACT_W-1:0]        act_ff, act_in;
   logic [mrb_pkg::CHAN_W-1:0]       chan_ff, chan_in;
   logic [mrb_pkg::OFF_W-1:0]        off_ff, off_in;
   logic [mrb_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [mrb_pkg::ELEMENT_BITS-1:0] wdat_ff, wdat_in;

   // result
   logic signed [mrb_pkg::GRANT_W-1:0] grant_ff, grant_in;
   logic [mrb_pkg::STAT_W-1:0]         stat_ff, stat_in;
   logic [mrb_pkg::WSP_W-1:0]          wsp_ff, wsp_in;
   logic signed [mrb_pkg::RSP_W-1:0]   rsp_ff, rsp_in;
   logic                               hit_ff, hit_in;

   logic [mrb_pkg::CNT_W-1:0]   s;
   logic [mrb_pkg::NCH_W-1:0]   chans;
   logic                        chan_ok;
   logic [mrb_pkg::CNT_W:0]     wsp_sum, fill_sum;
   logic [mrb_pkg::CNT_W:0]     wsp_w, fill_w;
   logic [mrb_pkg::POS_W-1:0]   wsp, filled;
   logic signed [mrb_pkg::GRANT_W-1:0] rsp_v;
   logic signed [mrb_pkg::GRANT_W:0]   space, cnt_s, take;
   logic                        is_write, is_read, element, partial, gt, reject;
   logic [mrb_pkg::POS_W-1:0]   n;
   logic [mrb_pkg::CNT_W-1:0]   adv_sum, slot_sum;
   logic [mrb_pkg::POS_W-1:0]   adv, slot, base;
   logic                        ram_we, ram_re;
   logic [mrb_pkg::ELEMENT_BITS-1:0] ram_rdata;

   always_comb begin
      if (ring_slots_ff < mrb_pkg::CNT_W'(2)) begin
         s = mrb_pkg::CNT_W'(2);
      end else if (ring_slots_ff > mrb_pkg::CNT_W'(mrb_pkg::SLOTS)) begin
         s = mrb_pkg::CNT_W'(mrb_pkg::SLOTS);
      end else begin
         s = ring_slots_ff;
      end
      chans = (nch_ff > mrb_pkg::NCH_W'(mrb_pkg::CHANNELS)) ?
              mrb_pkg::NCH_W'(mrb_pkg::CHANNELS) : nch_ff;
      chan_ok = {1'b0, chan_ff} < chans;

      wsp_sum = {1'b0, s} - 12'd1 - {2'b00, wp_ff} + {2'b00, rp_ff};
      wsp_w   = (wsp_sum >= {1'b0, s}) ? wsp_sum - {1'b0, s} : wsp_sum;
      wsp     = wsp_w[mrb_pkg::POS_W-1:0];
      fill_sum = {1'b0, s} + {2'b00, wp_ff} - {2'b00, rp_ff};
      fill_w   = (fill_sum >= {1'b0, s}) ? fill_sum - {1'b0, s} : fill_sum;
      filled   = fill_w[mrb_pkg::POS_W-1:0];
      rsp_v    = $signed({2'b00, filled}) - $signed({2'b00, reserve_ff});

      is_write = (act_ff == mrb_pkg::ACT_WRITE_ELEM) || (act_ff == mrb_pkg::ACT_COMMIT_WR);
      is_read  = (act_ff == mrb_pkg::ACT_READ_ELEM) || (act_ff == mrb_pkg::ACT_COMMIT_RD);
      element  = (act_ff == mrb_pkg::ACT_WRITE_ELEM) || (act_ff == mrb_pkg::ACT_READ_ELEM) ||
                 (act_ff == mrb_pkg::ACT_CHUNK_READ);
      partial  = is_write ? pwr_ff : prd_ff;
      space    = is_write ? $signed({3'b000, wsp}) : {rsp_v[mrb_pkg::GRANT_W-1], rsp_v};
      cnt_s    = $signed({2'b00, cnt_ff});
      gt       = cnt_s > space;
      take     = gt ? space : cnt_s;
      if (gt && !partial) begin
         take   = '0;
         reject = 1'b1;
      end else begin
         reject = (take <= 0);
      end
      n = take[mrb_pkg::POS_W-1:0];

      adv_sum = {1'b0, is_write ? wp_ff : rp_ff} + {1'b0, n};
      adv     = (adv_sum >= s) ? mrb_pkg::POS_W'(adv_sum - s) : adv_sum[mrb_pkg::POS_W-1:0];
      base    = (act_ff == mrb_pkg::ACT_WRITE_ELEM) ? wp_ff : rp_ff;
      slot_sum = {1'b0, base} + {1'b0, off_ff};
      slot     = (slot_sum >= s) ? mrb_pkg::POS_W'(slot_sum - s) :
                 slot_sum[mrb_pkg::POS_W-1:0];
   end

   always_comb begin
      ring_slots_in = ring_slots_ff;
      reserve_in    = reserve_ff;
      nch_in        = nch_ff;
      pwr_in        = pwr_ff;
      prd_in        = prd_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      ovf_in        = ovf_ff;
      udf_in        = udf_ff;
      grant_in      = grant_ff;
      stat_in       = stat_ff;
      wsp_in        = wsp_ff;
      rsp_in        = rsp_ff;
      hit_in        = hit_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;

      act_in  = cmd.capture ? req_action  : act_ff;
      chan_in = cmd.capture ? req_channel : chan_ff;
      off_in  = cmd.capture ? req_offset  : off_ff;
      cnt_in  = cmd.capture ? req_count   : cnt_ff;
      wdat_in = cmd.capture ? req_data    : wdat_ff;

      if (cmd.cfg_we) begin
         unique case (csr_index)
            mrb_pkg::CSR_RING_SLOTS: begin
               ring_slots_in = csr_wdata;
               wp_in         = '0;
               rp_in         = '0;
            end
            mrb_pkg::CSR_CHUNK_RESERVE: reserve_in = csr_wdata[mrb_pkg::RSV_W-1:0];
            mrb_pkg::CSR_CHANNELS:      nch_in     = csr_wdata[mrb_pkg::NCH_W-1:0];
            mrb_pkg::CSR_PARTIAL_WR:    pwr_in     = csr_wdata[0];
            mrb_pkg::CSR_PARTIAL_RD:    prd_in     = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.execute) begin
         wsp_in   = wsp;
         rsp_in   = rsp_v[mrb_pkg::RSP_W-1:0];
         grant_in = '0;
         stat_in  = mrb_pkg::STAT_OK;
         hit_in   = 1'b0;
         priority if (element && !chan_ok) begin
            stat_in = mrb_pkg::STAT_BAD_CHAN;
         end else if (is_write || is_read) begin
            grant_in = take[mrb_pkg::GRANT_W-1:0];
            if (reject) begin
               stat_in = is_write ? mrb_pkg::STAT_NO_SPACE : mrb_pkg::STAT_NO_DATA;
               if (act_ff == mrb_pkg::ACT_COMMIT_WR && ovf_ff != '1) begin
                  ovf_in = ovf_ff + 1'b1;
               end
               if (act_ff == mrb_pkg::ACT_COMMIT_RD && udf_ff != '1) begin
                  udf_in = udf_ff + 1'b1;
               end
            end else if (act_ff == mrb_pkg::ACT_COMMIT_WR) begin
               wp_in = adv;
            end else if (act_ff == mrb_pkg::ACT_COMMIT_RD) begin
               rp_in = adv;
            end else if (off_ff < n) begin
               ram_we = (act_ff == mrb_pkg::ACT_WRITE_ELEM);
               ram_re = (act_ff == mrb_pkg::ACT_READ_ELEM);
               hit_in = ram_re;
            end
         end else if (act_ff == mrb_pkg::ACT_CHUNK_READ) begin
            if (reserve_ff > filled || reserve_ff == '0) begin
               stat_in = mrb_pkg::STAT_NO_DATA;
               if (udf_ff != '1) begin
                  udf_in = udf_ff + 1'b1;
               end
            end else begin
               grant_in = $signed({2'b00, reserve_ff});
               if (off_ff < reserve_ff) begin
                  ram_re = 1'b1;
                  hit_in = 1'b1;
               end
            end
         end
      end
   end

   mrb_ram #(
      .WIDTH (mrb_pkg::ELEMENT_BITS),
      .DEPTH (mrb_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .rd_en   (ram_re),
      .addr    ({chan_ff, slot}),
      .wr_data (wdat_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_slots_ff <= mrb_pkg::CNT_W'(mrb_pkg::SLOTS);
         reserve_ff    <= '0;
         nch_ff        <= mrb_pkg::NCH_W'(mrb_pkg::CHANNELS);
         pwr_ff        <= 1'b0;
         prd_ff        <= 1'b0;
         wp_ff         <= '0;
         rp_ff         <= '0;
         ovf_ff        <= '0;
         udf_ff        <= '0;
      end else begin
         ring_slots_ff <= ring_slots_in;
         reserve_ff    <= reserve_in;
         nch_ff        <= nch_in;
         pwr_ff        <= pwr_in;
         prd_ff        <= prd_in;
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         ovf_ff        <= ovf_in;
         udf_ff        <= udf_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      chan_ff  <= chan_in;
      off_ff   <= off_in;
      cnt_ff   <= cnt_in;
      wdat_ff  <= wdat_in;
      grant_ff <= grant_in;
      stat_ff  <= stat_in;
      wsp_ff   <= wsp_in;
      rsp_ff   <= rsp_in;
      hit_ff   <= hit_in;
   end

   assign rsp_granted         = grant_ff;
   assign rsp_read_data       = hit_ff ? ram_rdata : '0;
   assign rsp_status          = stat_ff;
   assign rsp_write_space     = wsp_ff;
   assign rsp_read_space      = rsp_ff;
   assign rsp_overflow_count  = ovf_ff;
   assign rsp_underflow_count = udf_ff;

endmodule
`default_nettype wire

>>> rtl/mrb_checker.sv
`default_nettype none
module mrb_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               start,
   input wire logic                               busy,
   input wire logic                               rsp_valid,
   input wire logic signed [mrb_pkg::GRANT_W-1:0] rsp_granted,
   input wire logic [mrb_pkg::ELEMENT_BITS-1:0]   rsp_read_data,
   input wire logic [mrb_pkg::STAT_W-1:0]         rsp_status,
   input wire logic                               csr_ready
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_busy_resp: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid && !busy)
      else $error("response strobe missing after execute cycle");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_bad_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mrb_pkg::STAT_BAD_CHAN |->
         rsp_granted == '0 && rsp_read_data == '0)
      else $error("bad channel response carries data");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready)
      else $error("config port open during execute");

endmodule

bind multichannel_ring_buffer_core mrb_checker u_mrb_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_granted   (rsp_granted),
   .rsp_read_data (rsp_read_data),
   .rsp_status    (rsp_status),
   .csr_ready     (csr_ready)
);
`default_nettype wire
